FILE: sv/random_interval_pulse_generator_assert.svh
// assertion macros for the random interval pulse generator
// used by the top level only, no other dependencies
`ifndef RANDOM_INTERVAL_PULSE_GENERATOR_ASSERT_SVH
`define RANDOM_INTERVAL_PULSE_GENERATOR_ASSERT_SVH

// implication in the same cycle, off during reset
`define RIPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, off during reset
`define RIPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication into the next cycle, checked through reset too
`define RIPG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rip_pkg.sv
// shared types and constants of the random interval pulse generator
// no dependencies
package rip_pkg;

    localparam int VALUE_BITS_DEF = 17;
    localparam int COUNT_BITS_DEF = 26;

    localparam int MUL_BITS   = 16;
    localparam int MOD_BITS   = 17;
    localparam int ITER_BITS  = 8;
    localparam int PULSE_BITS = 16;
    localparam int DEB_BITS   = 20;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 20;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MULTIPLIER = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INCREMENT  = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS    = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_VALUE  = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED       = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_TICKS = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_TICKS = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEB_TICKS  = 4'd7;

    localparam logic [MUL_BITS-1:0]   RST_MULTIPLIER  = 16'd3;
    localparam logic [MOD_BITS-1:0]   RST_INCREMENT   = 17'd5;
    localparam logic [MOD_BITS-1:0]   RST_MODULUS     = 17'd79998;
    localparam logic [MOD_BITS-1:0]   RST_MIN_VALUE   = 17'd18;
    localparam logic [MOD_BITS-1:0]   RST_SEED        = 17'd0;
    localparam logic [ITER_BITS-1:0]  RST_ITER_TICKS  = 8'd5;
    localparam logic [PULSE_BITS-1:0] RST_PULSE_TICKS = 16'd30;
    localparam logic [DEB_BITS-1:0]   RST_DEB_TICKS   = 20'd15000;

    typedef struct packed {
        logic start_n;
        logic stop_n;
    } t_in;

    typedef struct packed {
        logic pulse_out;
        logic led_green;
        logic running;
    } t_out;

    typedef struct packed {
        logic [MUL_BITS-1:0]   multiplier;
        logic [MOD_BITS-1:0]   increment;
        logic [MOD_BITS-1:0]   modulus;
        logic [MOD_BITS-1:0]   min_value;
        logic [MOD_BITS-1:0]   seed;
        logic [ITER_BITS-1:0]  iteration_ticks;
        logic [PULSE_BITS-1:0] pulse_ticks;
        logic [DEB_BITS-1:0]   debounce_ticks;
    } t_cfg;

endpackage

FILE: sv/random_interval_pulse_generator.sv
// random interval pulse generator: one result per timer tick, and a tick is taken only
// while the result register is free; a tick that starts a gap still gives its result, then the
// congruential step keeps the input side busy while it runs, through the bit-serial remainder
// unit when the modulus is not zero (one pass, or two when a retry is taken)
// synchronous active-low reset: stopped, check phase, value = seed, registers at defaults
// depends on rip_pkg, rip_lcg, rip_remainder and the assertion macro header
`include "random_interval_pulse_generator_assert.svh"

module random_interval_pulse_generator
    import rip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in                       i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out                      o_out_data,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    typedef enum logic [2:0] {
        PH_CHECK,
        PH_DEBOUNCE,
        PH_GAP,
        PH_PULSE,
        PH_STEP
    } t_phase;

    localparam logic [1:0] CASE_NONE  = 2'd0;
    localparam logic [1:0] CASE_START = 2'd1;
    localparam logic [1:0] CASE_STOP  = 2'd2;
    localparam logic [1:0] CASE_BOTH  = 2'd3;

    t_phase                r_phase, n_phase;
    logic                  r_run, n_run;
    logic [VALUE_BITS-1:0] r_rand, n_rand;
    logic [COUNT_BITS-1:0] r_wait, n_wait;
    logic [1:0]            r_pend, n_pend;
    t_cfg                  r_cfg, n_cfg;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic                  in_fire;
    logic                  lcg_start;
    logic                  lcg_done;
    logic [VALUE_BITS-1:0] lcg_value;
    logic [COUNT_BITS-1:0] lcg_wait;
    logic                  start_p;
    logic                  stop_p;
    logic [1:0]            chk_case;
    logic                  run_new;
    logic                  do_resolve;
    logic                  pulse;

    assign o_in_ready = (r_phase != PH_STEP) && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign start_p    = !i_in_data.start_n;
    assign stop_p     = !i_in_data.stop_n;

    rip_lcg #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lcg_start),
        .i_value (r_rand),
        .i_cfg   (r_cfg),
        .o_done  (lcg_done),
        .o_value (lcg_value),
        .o_wait  (lcg_wait)
    );

    always_comb begin
        if (start_p && !stop_p && !r_run) begin
            chk_case = CASE_START;
        end else if (!start_p && stop_p && r_run) begin
            chk_case = CASE_STOP;
        end else if (start_p && stop_p && r_run) begin
            chk_case = CASE_BOTH;
        end else begin
            chk_case = CASE_NONE;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_run       = r_run;
        n_rand      = r_rand;
        n_wait      = r_wait;
        n_pend      = r_pend;
        n_cfg       = r_cfg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        run_new     = r_run;
        do_resolve  = 1'b0;
        pulse       = 1'b0;
        lcg_start   = 1'b0;

        if (in_fire) begin
            case (r_phase)
                PH_CHECK: begin
                    if (chk_case != CASE_NONE) begin
                        n_pend  = chk_case;
                        n_wait  = (r_cfg.debounce_ticks == '0) ? COUNT_BITS'(1)
                                                                : COUNT_BITS'(r_cfg.debounce_ticks);
                        n_phase = PH_DEBOUNCE;
                    end else begin
                        do_resolve = 1'b1;
                    end
                end
                PH_DEBOUNCE: begin
                    if (r_wait > COUNT_BITS'(1)) begin
                        n_wait = r_wait - COUNT_BITS'(1);
                    end else begin
                        if (r_pend == CASE_START) begin
                            run_new = start_p && !stop_p;
                        end else if (r_pend == CASE_STOP && !start_p && stop_p) begin
                            run_new = 1'b0;
                        end else if (r_pend == CASE_BOTH && start_p && stop_p) begin
                            run_new = 1'b0;
                        end
                        n_wait     = '0;
                        do_resolve = 1'b1;
                    end
                end
                PH_GAP: begin
                    if (r_wait > COUNT_BITS'(1)) begin
                        n_wait = r_wait - COUNT_BITS'(1);
                    end else begin
                        n_wait  = (r_cfg.pulse_ticks == '0) ? COUNT_BITS'(1)
                                                             : COUNT_BITS'(r_cfg.pulse_ticks);
                        n_phase = PH_PULSE;
                    end
                end
                PH_PULSE: begin
                    pulse = 1'b1;
                    if (r_wait > COUNT_BITS'(1)) begin
                        n_wait = r_wait - COUNT_BITS'(1);
                    end else begin
                        n_wait  = '0;
                        n_phase = PH_CHECK;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (do_resolve) begin
                n_pend = CASE_NONE;
                if (run_new) begin
                    lcg_start = 1'b1;
                    n_phase   = PH_STEP;
                end else begin
                    n_phase = PH_CHECK;
                end
            end

            n_run           = run_new;
            n_out_valid     = 1'b1;
            n_out.pulse_out = pulse;
            n_out.led_green = run_new;
            n_out.running   = run_new;
        end

        if (r_phase == PH_STEP && lcg_done) begin
            n_rand  = lcg_value;
            n_wait  = lcg_wait;
            n_phase = PH_GAP;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MULTIPLIER:  n_cfg.multiplier      = i_cfg_wdata[MUL_BITS-1:0];
                REG_INCREMENT:   n_cfg.increment       = i_cfg_wdata[MOD_BITS-1:0];
                REG_MODULUS:     n_cfg.modulus         = i_cfg_wdata[MOD_BITS-1:0];
                REG_MIN_VALUE:   n_cfg.min_value       = i_cfg_wdata[MOD_BITS-1:0];
                REG_SEED: begin
                    n_cfg.seed = i_cfg_wdata[MOD_BITS-1:0];
                    n_rand     = VALUE_BITS'(i_cfg_wdata[MOD_BITS-1:0]);
                end
                REG_ITER_TICKS:  n_cfg.iteration_ticks = i_cfg_wdata[ITER_BITS-1:0];
                REG_PULSE_TICKS: n_cfg.pulse_ticks     = i_cfg_wdata[PULSE_BITS-1:0];
                REG_DEB_TICKS:   n_cfg.debounce_ticks  = i_cfg_wdata[DEB_BITS-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase                 <= PH_CHECK;
            r_run                   <= 1'b0;
            r_rand                  <= VALUE_BITS'(RST_SEED);
            r_wait                  <= '0;
            r_pend                  <= CASE_NONE;
            r_cfg.multiplier        <= RST_MULTIPLIER;
            r_cfg.increment         <= RST_INCREMENT;
            r_cfg.modulus           <= RST_MODULUS;
            r_cfg.min_value         <= RST_MIN_VALUE;
            r_cfg.seed              <= RST_SEED;
            r_cfg.iteration_ticks   <= RST_ITER_TICKS;
            r_cfg.pulse_ticks       <= RST_PULSE_TICKS;
            r_cfg.debounce_ticks    <= RST_DEB_TICKS;
            r_out_valid             <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_run       <= n_run;
            r_rand      <= n_rand;
            r_wait      <= n_wait;
            r_pend      <= n_pend;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RIPG_ASSERT_IMPL(a_step_not_ready, i_clk, i_rst_n, r_phase == PH_STEP, !o_in_ready, "input taken during congruential step")
    `RIPG_ASSERT_IMPL(a_lcg_done_in_step, i_clk, i_rst_n, lcg_done, r_phase == PH_STEP, "step result outside step phase")
    `RIPG_ASSERT_NEXT(a_pulse_out_high, i_clk, i_rst_n, in_fire && r_phase == PH_PULSE, r_out_valid && r_out.pulse_out, "pulse tick gave low output")
    `RIPG_ASSERT_NEXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, r_phase == PH_CHECK && !r_out_valid && !r_run, "reset state wrong")

endmodule

FILE: sv/rip_remainder.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on rip_pkg
module rip_remainder
    import rip_pkg::*;
#(
    parameter int DIV_BITS = VALUE_BITS_DEF + MOD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [MOD_BITS-1:0] i_modulus,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_rem
);

    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIV_BITS-1:0] r_div;
    logic [MOD_BITS-1:0] r_mod;
    logic [MOD_BITS-1:0] r_rem;

    logic [MOD_BITS:0]   rem_sh;
    logic [MOD_BITS:0]   rem_diff;
    logic                last;

    assign rem_sh   = {r_rem, r_div[DIV_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, r_mod};
    assign last     = (r_cnt == CNT_BITS'(DIV_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_mod <= i_modulus;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[DIV_BITS-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_mod}) begin
                r_rem <= rem_diff[MOD_BITS-1:0];
            end else begin
                r_rem <= rem_sh[MOD_BITS-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: sv/rip_lcg.sv
// congruential step sequencer: shared multiplier, remainder unit, retry and gap scaling
// depends on rip_pkg and rip_remainder
module rip_lcg
    import rip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    input  t_cfg                  i_cfg,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [COUNT_BITS-1:0] o_wait
);

    localparam int W  = VALUE_BITS + MUL_BITS + 1;
    localparam int XW = (VALUE_BITS > MOD_BITS) ? VALUE_BITS : MOD_BITS;

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_MOD,
        L_REM,
        L_CHK,
        L_SCALE,
        L_OUT
    } t_lstate;

    t_lstate               r_state, n_state;
    logic [W-1:0]          r_prod, n_prod;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_first, n_first;
    logic                  r_done, n_done;
    logic [COUNT_BITS-1:0] r_wait, n_wait;

    logic [MUL_BITS-1:0]   mul_a;
    logic [VALUE_BITS:0]   mul_b;
    logic [W-1:0]          mul_p;
    logic [W-1:0]          sum;
    logic [ITER_BITS-1:0]  it_eff;
    logic                  rem_start;
    logic                  rem_done;
    logic [MOD_BITS-1:0]   rem;

    assign it_eff = (i_cfg.iteration_ticks == '0) ? ITER_BITS'(1) : i_cfg.iteration_ticks;
    assign mul_a  = (r_state == L_SCALE) ? MUL_BITS'(it_eff) : i_cfg.multiplier;
    assign mul_b  = (r_state == L_SCALE) ? ({1'b0, r_val} + (VALUE_BITS + 1)'(1))
                                         : {1'b0, r_val};
    assign mul_p  = W'(mul_a) * W'(mul_b);
    assign sum    = r_prod + W'(i_cfg.increment);
    assign rem_start = (r_state == L_MOD) && (i_cfg.modulus != '0);

    rip_remainder #(
        .DIV_BITS (W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (sum),
        .i_modulus  (i_cfg.modulus),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_val   = r_val;
        n_first = r_first;
        n_done  = 1'b0;
        n_wait  = r_wait;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_val   = i_value;
                    n_first = 1'b1;
                    n_state = L_MUL;
                end
            end
            L_MUL: begin
                n_prod  = mul_p;
                n_state = L_MOD;
            end
            L_MOD: begin
                if (i_cfg.modulus == '0) begin
                    n_val   = sum[VALUE_BITS-1:0];
                    n_state = L_CHK;
                end else begin
                    n_state = L_REM;
                end
            end
            L_REM: begin
                if (rem_done) begin
                    n_val   = VALUE_BITS'(rem);
                    n_state = L_CHK;
                end
            end
            L_CHK: begin
                if (r_first && (XW'(r_val) < XW'(i_cfg.min_value))) begin
                    n_first = 1'b0;
                    n_state = L_MUL;
                end else begin
                    n_state = L_SCALE;
                end
            end
            L_SCALE: begin
                n_prod  = mul_p;
                n_state = L_OUT;
            end
            L_OUT: begin
                n_wait  = COUNT_BITS'(r_prod);
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_prod  <= n_prod;
        r_val   <= n_val;
        r_first <= n_first;
        r_wait  <= n_wait;
    end

    assign o_done  = r_done;
    assign o_value = r_val;
    assign o_wait  = r_wait;

endmodule

FILE: tb/pulse_level_checker.sv
`timescale 1ns / 100ps
// checker for the random interval pulse generator: tracks register writes, predicts
// the output levels of every tick transfer and compares them with the result transfers
// depends on rip_pkg only
module pulse_level_checker
    import rip_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_tick_valid,
    input  logic                      i_tick_ready,
    input  t_in                       i_tick_data,
    input  logic                      i_level_valid,
    input  logic                      i_level_ready,
    input  t_out                      i_level_data,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output int                        o_mismatches,
    output int                        o_levels_due
);

    localparam int VB = VALUE_BITS_DEF;
    localparam int CB = COUNT_BITS_DEF;

    typedef enum logic [1:0] {SEQ_CHECK, SEQ_DEBOUNCE, SEQ_GAP, SEQ_PULSE} t_seq;
    typedef enum logic [1:0] {PRESS_NONE, PRESS_START, PRESS_STOP, PRESS_BOTH} t_press;

    t_cfg          cfg;
    logic          run_mode;
    t_seq          seq;
    t_press        press;
    logic [VB-1:0] rand_val;
    logic [CB-1:0] count;
    t_out          due_levels[$];

    function automatic logic [63:0] at_least_one(input logic [63:0] n);
        return (n == 64'd0) ? 64'd1 : n;
    endfunction

    function automatic logic [VB-1:0] lcg_step(input logic [VB-1:0] v);
        logic [63:0] s;
        s = 64'(cfg.multiplier) * 64'(v) + 64'(cfg.increment);
        if (cfg.modulus != '0) begin
            s = s % 64'(cfg.modulus);
        end
        return s[VB-1:0];
    endfunction

    // mode decided: start a gap when running, else check again
    function automatic void start_gap_or_check();
        logic [VB-1:0] v;
        logic [63:0]   span;
        press = PRESS_NONE;
        if (run_mode) begin
            v = lcg_step(rand_val);
            if (v < cfg.min_value) begin
                v = lcg_step(v);
            end
            rand_val = v;
            span = (64'(v) + 64'd1) * at_least_one(64'(cfg.iteration_ticks));
            count = span[CB-1:0];
            seq = SEQ_GAP;
        end else begin
            seq = SEQ_CHECK;
        end
    endfunction

    function automatic t_out tick_outcome(input t_in t);
        logic        start_p;
        logic        stop_p;
        logic [63:0] load;
        t_out        o;
        start_p = !t.start_n;
        stop_p = !t.stop_n;
        o.pulse_out = 1'b0;
        case (seq)
            SEQ_CHECK: begin
                if (start_p && !stop_p && !run_mode) begin
                    press = PRESS_START;
                end else if (!start_p && stop_p && run_mode) begin
                    press = PRESS_STOP;
                end else if (start_p && stop_p && run_mode) begin
                    press = PRESS_BOTH;
                end else begin
                    press = PRESS_NONE;
                end
                if (press != PRESS_NONE) begin
                    load = at_least_one(64'(cfg.debounce_ticks));
                    count = load[CB-1:0];
                    seq = SEQ_DEBOUNCE;
                end else begin
                    start_gap_or_check();
                end
            end
            SEQ_DEBOUNCE: begin
                if (count > 1) begin
                    count = count - 1'b1;
                end else begin
                    case (press)
                        PRESS_START: run_mode = start_p && !stop_p;
                        PRESS_STOP: if (!start_p && stop_p) run_mode = 1'b0;
                        PRESS_BOTH: if (start_p && stop_p) run_mode = 1'b0;
                        default: ;
                    endcase
                    count = '0;
                    start_gap_or_check();
                end
            end
            SEQ_GAP: begin
                if (count > 1) begin
                    count = count - 1'b1;
                end else begin
                    load = at_least_one(64'(cfg.pulse_ticks));
                    count = load[CB-1:0];
                    seq = SEQ_PULSE;
                end
            end
            default: begin
                o.pulse_out = 1'b1;
                if (count > 1) begin
                    count = count - 1'b1;
                end else begin
                    count = '0;
                    seq = SEQ_CHECK;
                end
            end
        endcase
        o.led_green = run_mode;
        o.running = run_mode;
        return o;
    endfunction

    task automatic report_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    initial begin
        o_mismatches = 0;
        o_levels_due = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            cfg.multiplier = RST_MULTIPLIER;
            cfg.increment = RST_INCREMENT;
            cfg.modulus = RST_MODULUS;
            cfg.min_value = RST_MIN_VALUE;
            cfg.seed = RST_SEED;
            cfg.iteration_ticks = RST_ITER_TICKS;
            cfg.pulse_ticks = RST_PULSE_TICKS;
            cfg.debounce_ticks = RST_DEB_TICKS;
            run_mode = 1'b0;
            seq = SEQ_CHECK;
            press = PRESS_NONE;
            rand_val = VB'(RST_SEED);
            count = '0;
            due_levels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MULTIPLIER: cfg.multiplier = i_cfg_wdata[MUL_BITS-1:0];
                    REG_INCREMENT: cfg.increment = i_cfg_wdata[MOD_BITS-1:0];
                    REG_MODULUS: cfg.modulus = i_cfg_wdata[MOD_BITS-1:0];
                    REG_MIN_VALUE: cfg.min_value = i_cfg_wdata[MOD_BITS-1:0];
                    REG_SEED: begin
                        cfg.seed = i_cfg_wdata[MOD_BITS-1:0];
                        rand_val = VB'(cfg.seed);
                    end
                    REG_ITER_TICKS: cfg.iteration_ticks = i_cfg_wdata[ITER_BITS-1:0];
                    REG_PULSE_TICKS: cfg.pulse_ticks = i_cfg_wdata[PULSE_BITS-1:0];
                    REG_DEB_TICKS: cfg.debounce_ticks = i_cfg_wdata[DEB_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_level_valid && i_level_ready) begin
                if (due_levels.size() == 0) begin
                    $display("%0t: result transfer with none due, expected nothing actual %b",
                             $time, i_level_data);
                    o_mismatches++;
                end else begin
                    want = due_levels.pop_front();
                    report_field("pulse_out", want.pulse_out, i_level_data.pulse_out);
                    report_field("led_green", want.led_green, i_level_data.led_green);
                    report_field("running", want.running, i_level_data.running);
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                due_levels.push_back(tick_outcome(i_tick_data));
            end
        end
        o_levels_due = due_levels.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the random interval pulse generator: reset, register settings,
// button tick stimulus, receiver stalls and the verdict
// depends on rip_pkg, random_interval_pulse_generator and pulse_level_checker
module tb_top;
    import rip_pkg::*;

    localparam int  HALF_PERIOD  = 5;
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  SETTLE_WAIT  = 120;
    localparam t_in BTN_NONE     = 2'b11;
    localparam t_in BTN_START    = 2'b01;
    localparam t_in BTN_STOP     = 2'b10;
    localparam t_in BTN_BOTH     = 2'b00;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      tick_valid = 1'b0;
    logic                      tick_ready;
    t_in                       tick_data = BTN_NONE;
    logic                      level_valid;
    logic                      level_ready = 1'b0;
    t_out                      level_data;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    int                        mismatches;
    int                        levels_due;
    int                        cycles = 0;
    int                        burst_left = 0;
    logic [15:0]               ready_pattern = '1;
    int                        pattern_age = 0;

    random_interval_pulse_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_ready  (tick_ready),
        .i_in_data   (tick_data),
        .o_out_valid (level_valid),
        .i_out_ready (level_ready),
        .o_out_data  (level_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    pulse_level_checker u_level_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_tick_valid  (tick_valid),
        .i_tick_ready  (tick_ready),
        .i_tick_data   (tick_data),
        .i_level_valid (level_valid),
        .i_level_ready (level_ready),
        .i_level_data  (level_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_levels_due  (levels_due)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("random_interval_pulse_generator regression: fail");
            $finish;
        end
    end

    // receiver: rotating ready pattern, reloaded now and then, never all zero
    always @(negedge clk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = '1;
                1: ready_pattern = 16'($urandom) | 16'h0001;
                2: ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
                default: ready_pattern = 16'($urandom) | 16'h8421;
            endcase
            pattern_age = $urandom_range(16, 96);
        end else begin
            pattern_age--;
        end
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        level_ready <= ready_pattern[0];
    end

    function automatic t_cfg make_setting(input int unsigned mul, input int unsigned inc,
                                          input int unsigned modv, input int unsigned minv,
                                          input int unsigned seedv, input int unsigned iter,
                                          input int unsigned pulse, input int unsigned deb);
        t_cfg s;
        s.multiplier = MUL_BITS'(mul);
        s.increment = MOD_BITS'(inc);
        s.modulus = MOD_BITS'(modv);
        s.min_value = MOD_BITS'(minv);
        s.seed = MOD_BITS'(seedv);
        s.iteration_ticks = ITER_BITS'(iter);
        s.pulse_ticks = PULSE_BITS'(pulse);
        s.debounce_ticks = DEB_BITS'(deb);
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    // unused indexes get a random write too, which must change nothing
    task automatic apply_setting(input t_cfg s);
        write_reg(REG_MULTIPLIER, CFG_DATA_BITS'(s.multiplier));
        write_reg(REG_INCREMENT, CFG_DATA_BITS'(s.increment));
        write_reg(REG_MODULUS, CFG_DATA_BITS'(s.modulus));
        write_reg(REG_MIN_VALUE, CFG_DATA_BITS'(s.min_value));
        write_reg(REG_SEED, CFG_DATA_BITS'(s.seed));
        write_reg(REG_ITER_TICKS, CFG_DATA_BITS'(s.iteration_ticks));
        write_reg(REG_PULSE_TICKS, CFG_DATA_BITS'(s.pulse_ticks));
        write_reg(REG_DEB_TICKS, CFG_DATA_BITS'(s.debounce_ticks));
        write_reg(REG_DEB_TICKS + CFG_INDEX_BITS'($urandom_range(1, 8)),
                  CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // sender works in bursts with random gaps between them
    task automatic issue_tick(input t_in lv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                tick_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        tick_valid <= 1'b1;
        tick_data <= lv;
        @(posedge clk);
        while (!tick_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold(input t_in lv, input int n);
        repeat (n) issue_tick(lv);
    endtask

    // stop sending until every due level is back and the step unit is quiet
    task automatic settle();
        tick_valid <= 1'b0;
        burst_left = 0;
        while (levels_due != 0) @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    // button episodes: mostly held presses, some short noise
    task automatic random_run(input int n, input bit allow_start);
        int   sent;
        int   len;
        int   pick;
        t_in  lv;
        bit   noisy;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            noisy = 1'b0;
            if (pick < 30) begin
                lv = BTN_NONE;
                len = $urandom_range(1, 30);
            end else if (pick < 55) begin
                lv = BTN_START;
                len = $urandom_range(1, 6);
            end else if (pick < 80) begin
                lv = BTN_STOP;
                len = $urandom_range(1, 60);
            end else if (pick < 92) begin
                lv = BTN_BOTH;
                len = $urandom_range(1, 60);
            end else begin
                noisy = 1'b1;
                len = $urandom_range(1, 6);
            end
            repeat (len) begin
                if (noisy) begin
                    lv = t_in'($urandom_range(0, 3));
                end
                if (!allow_start && lv == BTN_START) begin
                    lv = BTN_BOTH;
                end
                issue_tick(lv);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, stopped, no start alone
        hold(BTN_NONE, 1);
        hold(BTN_STOP, 1);
        hold(BTN_BOTH, 1);
        settle();

        // widest counts and values while stopped
        apply_setting(make_setting(65535, 131071, 131071, 131071, 131071, 255, 65535,
                                   1048575));
        random_run(4, 1'b0);
        settle();

        // short directed script: min above modulus forces the retry
        apply_setting(make_setting(3, 5, 3, 4, 0, 1, 1, 1));
        hold(BTN_START, 1);
        hold(BTN_NONE, 1);
        hold(BTN_START, 2);
        hold(BTN_NONE, 5);
        hold(BTN_STOP, 1);
        hold(BTN_NONE, 1);
        hold(BTN_STOP, 6);
        hold(BTN_START, 2);
        hold(BTN_BOTH, 4);
        settle();

        // zero counts with widest multiplier, increment and seed
        apply_setting(make_setting(65535, 131071, 7, 0, 131071, 0, 0, 0));
        random_run(90, 1'b1);
        settle();

        // widest modulus, value always zero after the retry, longest iteration
        apply_setting(make_setting(0, 131071, 131071, 131071, 5, 255, 3, 1));
        random_run(200, 1'b1);
        settle();

        // no reduction, step overflows the value width
        apply_setting(make_setting(2, 0, 0, 1, 65536, 2, 1, 3));
        random_run(70, 1'b1);
        settle();

        // modulus of two
        apply_setting(make_setting($urandom_range(0, 65535), $urandom_range(0, 131071), 2,
                                   $urandom_range(0, 3), $urandom_range(0, 131071),
                                   $urandom_range(0, 4), $urandom_range(0, 5),
                                   $urandom_range(0, 4)));
        random_run(70, 1'b1);
        settle();

        repeat (4) begin
            apply_setting(make_setting($urandom_range(0, 65535), $urandom_range(0, 131071),
                                       $urandom_range(2, 40), $urandom_range(0, 40),
                                       $urandom_range(0, 131071), $urandom_range(0, 4),
                                       $urandom_range(0, 5), $urandom_range(0, 4)));
            random_run(80, 1'b1);
            settle();
        end

        if (mismatches == 0) begin
            $display("random_interval_pulse_generator regression: pass");
        end else begin
            $display("random_interval_pulse_generator regression: fail");
        end
        $finish;
    end

endmodule
